>>> rtl/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin time-slice scheduler.
// ---------------------------------------------------------------------------
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd60;

  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int CLOCK_W = 32;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = ID_W + TIME_W;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = 1;
  localparam int CMD_CW    = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b0;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SLICE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_SLICE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]   pid;
    logic [TIME_W-1:0] burst;
  } cmd_t;

endpackage

>>> rtl/rrts_ram.sv
// ---------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rrts_front.sv
// ---------------------------------------------------------------------------
// rrts_front
// Accepts items, classifies them by action and holds them in a short
// command queue until the back end takes them.
// ---------------------------------------------------------------------------
module rrts_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [rrts_pkg::ID_W-1:0]   in_process_id,
  input  logic [rrts_pkg::TIME_W-1:0] in_burst_time,
  output logic                    cmd_valid,
  output rrts_pkg::cmd_t          cmd,
  input  logic                    cmd_pop
);
  import rrts_pkg::*;

  cmd_t              slot_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wptr_r;
  logic [CMD_AW-1:0] rptr_r;
  logic [CMD_CW-1:0] cnt_r;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign busy      = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cmd_in.op    = in_action ? OP_SLICE : OP_ADD;
    cmd_in.pid   = in_process_id;
    cmd_in.burst = in_burst_time;
  end

  assign cmd = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/rrts_back.sv
// ---------------------------------------------------------------------------
// rrts_back
// Executes queued commands against the process ring: add at tail, or run
// one slice from the head and requeue or retire the process.
// ---------------------------------------------------------------------------
module rrts_back #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  rrts_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic [rrts_pkg::TIME_W-1:0]   quantum,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [rrts_pkg::ID_W-1:0]     out_slice_process_id,
  output logic [rrts_pkg::CLOCK_W-1:0]  out_slice_start,
  output logic [rrts_pkg::TIME_W-1:0]   out_slice_length,
  output logic [rrts_pkg::TIME_W-1:0]   out_remaining_after,
  output logic                          out_finished,
  output logic [rrts_pkg::COUNT_W-1:0]  out_queue_count
);
  import rrts_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CLOCK_W-1:0] elapsed_r, elapsed_nxt;

  logic               valid_r, valid_nxt;
  status_t            status_r, status_nxt;
  logic [ID_W-1:0]    sid_r, sid_nxt;
  logic [CLOCK_W-1:0] sstart_r, sstart_nxt;
  logic [TIME_W-1:0]  slen_r, slen_nxt;
  logic [TIME_W-1:0]  srem_r, srem_nxt;
  logic               sfin_r, sfin_nxt;
  logic [CW-1:0]      qcnt_r, qcnt_nxt;
  logic [CW+COUNT_W-1:0] qcnt_ext;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_rem;
  logic [TIME_W-1:0]  run_len;
  logic [TIME_W-1:0]  rem_left;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  rrts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign rd_id    = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_rem   = ram_rdata[TIME_W-1:0];
  assign run_len  = (rd_rem > quantum) ? quantum : rd_rem;
  assign rem_left = rd_rem - run_len;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = tail_r;
    ram_wdata   = {cmd.pid, cmd.burst};
    ram_re      = 1'b0;
    valid_nxt   = 1'b0;
    status_nxt  = ST_ADDED;
    sid_nxt     = '0;
    sstart_nxt  = '0;
    slen_nxt    = '0;
    srem_nxt    = '0;
    sfin_nxt    = 1'b0;
    qcnt_nxt    = count_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_ADD: begin
              valid_nxt = 1'b1;
              if (count_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                tail_nxt   = next_slot(tail_r);
                count_nxt  = count_r + 1'b1;
                qcnt_nxt   = count_r + 1'b1;
                status_nxt = ST_ADDED;
              end
            end
            OP_SLICE: begin
              if (count_r == '0) begin
                valid_nxt  = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                state_nxt = BK_READ;
              end
            end
            default: begin
              valid_nxt = 1'b0;
            end
          endcase
        end
      end
      BK_READ: begin
        // head entry is on the RAM output now
        state_nxt   = BK_IDLE;
        valid_nxt   = 1'b1;
        status_nxt  = ST_SLICE;
        sid_nxt     = rd_id;
        sstart_nxt  = elapsed_r;
        slen_nxt    = run_len;
        srem_nxt    = rem_left;
        elapsed_nxt = elapsed_r + CLOCK_W'(run_len);
        head_nxt    = next_slot(head_r);
        if (rem_left != '0) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_id, rem_left};
          tail_nxt  = next_slot(tail_r);
        end else begin
          sfin_nxt  = 1'b1;
          count_nxt = count_r - 1'b1;
          qcnt_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    sid_r    <= sid_nxt;
    sstart_r <= sstart_nxt;
    slen_r   <= slen_nxt;
    srem_r   <= srem_nxt;
    sfin_r   <= sfin_nxt;
    qcnt_r   <= qcnt_nxt;
  end

  assign qcnt_ext = {{COUNT_W{1'b0}}, qcnt_r};

  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_slice_process_id = sid_r;
  assign out_slice_start      = sstart_r;
  assign out_slice_length     = slen_r;
  assign out_remaining_after  = srem_r;
  assign out_finished         = sfin_r;
  assign out_queue_count      = qcnt_ext[COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("ring count beyond depth");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_READ |=> state_r == BK_IDLE)
    else $error("read state held past one cycle");

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE && cmd_valid) |=> (valid_r || state_r == BK_READ))
    else $error("popped command produced no result");

  a_finish_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_SLICE && sfin_r) |-> srem_r == '0)
    else $error("finished slice with time remaining");

endmodule

>>> rtl/round_robin_time_slice_scheduler.sv
// ---------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin ready queue with a fixed quantum: add processes at the tail,
// run slices from the head, requeue or retire each process.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake                      Payload
//  -------  -----------------------------  -----------------------------------
//  input    start & !busy                  in_action, in_process_id,
//                                          in_burst_time
//  result   out_valid, one cycle           out_status, out_slice_process_id,
//                                          out_slice_start, out_slice_length,
//                                          out_remaining_after, out_finished,
//                                          out_queue_count
//  config   psel & penable & pwrite        paddr, pwdata, prdata (pready = 1)
//
// An add item holds the back end in its idle state; a slice item also
// takes the read state, set by the registered read of the process ring.
// Each result comes from a register loaded as that work ends.
// A two-item command queue parts the front from the back; busy rises only
// when that queue is full. The ring needs no clearing after reset, so items
// are taken on the first cycle after rst_n rises. The receiver cannot stall.
// ---------------------------------------------------------------------------
module round_robin_time_slice_scheduler #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [rrts_pkg::ID_W-1:0]     in_process_id,
  input  logic [rrts_pkg::TIME_W-1:0]   in_burst_time,
  // result channel
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [rrts_pkg::ID_W-1:0]     out_slice_process_id,
  output logic [rrts_pkg::CLOCK_W-1:0]  out_slice_start,
  output logic [rrts_pkg::TIME_W-1:0]   out_slice_length,
  output logic [rrts_pkg::TIME_W-1:0]   out_remaining_after,
  output logic                          out_finished,
  output logic [rrts_pkg::COUNT_W-1:0]  out_queue_count,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rrts_pkg::*;

  logic [TIME_W-1:0]    quantum_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;
  logic                 cmd_valid;
  logic                 cmd_pop;
  cmd_t                 cmd;

  // Decode the register index from the word address; low bits are ignored.
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_write && reg_idx == REG_QUANTUM) begin
      quantum_r <= pwdata[TIME_W-1:0];
    end
  end

  // Return zero for any address beyond the register list.
  always_comb begin
    if (reg_idx == REG_QUANTUM) begin
      prdata = {{(32-TIME_W){1'b0}}, quantum_r};
    end else begin
      prdata = '0;
    end
  end

  // Front: take and classify items, hold them in the command queue.
  rrts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_process_id (in_process_id),
    .in_burst_time (in_burst_time),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Back: drive the ring, the elapsed-time clock and the result register.
  rrts_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop),
    .quantum              (quantum_r),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slice_process_id (out_slice_process_id),
    .out_slice_start      (out_slice_start),
    .out_slice_length     (out_slice_length),
    .out_remaining_after  (out_remaining_after),
    .out_finished         (out_finished),
    .out_queue_count      (out_queue_count)
  );

endmodule

>>> sim/tb_round_robin_time_slice_scheduler.sv
// ---------------------------------------------------------------------------
// tb_round_robin_time_slice_scheduler
// Self-checking bench for the round-robin time-slice scheduler. A scoreboard
// keeps its own copy of the ring, elapsed time and quantum, predicts one
// report per accepted item and compares every strobed result field by field.
// The stimulus starts with a directed run through empty, full, zero-burst and
// requeue cases. Random phases follow at several quantum settings, including
// zero and both ends of the range, and a short stretch pairs full-burst adds
// with full-quantum slices. Gaps of random length are placed between items.
// ---------------------------------------------------------------------------
module tb_round_robin_time_slice_scheduler;
  import rrts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  QUANTUM_ADDR = {REG_QUANTUM, 2'b00};
  // index 1 holds no register: a write there must leave the quantum alone
  localparam logic [2:0]  SPARE_ADDR   = {~REG_QUANTUM, 2'b00};

  // one report as the block strobes it out
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     pid;
    logic [CLOCK_W-1:0]  start_at;
    logic [TIME_W-1:0]   length;
    logic [TIME_W-1:0]   left;
    logic                done;
    logic [COUNT_W-1:0]  count;
  } slice_report_t;

  // -------------------------------------------------------------------------
  // Scoreboard: private copy of the ready ring plus the queue of reports due
  // -------------------------------------------------------------------------
  class slice_scoreboard;
    logic [ID_W-1:0]    ring_pid  [QUEUE_DEPTH_DEF];
    logic [TIME_W-1:0]  ring_left [QUEUE_DEPTH_DEF];
    int unsigned        head, tail, depth;
    logic [CLOCK_W-1:0] clock_now;
    logic [TIME_W-1:0]  quantum;
    slice_report_t      reports_due[$];
    int unsigned        errors, items, reports, finishes;
    int unsigned        status_seen[4];
    bit                 wrapped;

    function new();
      head = 0;
      tail = 0;
      depth = 0;
      clock_now = '0;
      quantum = QUANTUM_RESET;
      errors = 0;
      items = 0;
      reports = 0;
      finishes = 0;
      wrapped = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_quantum(logic [TIME_W-1:0] q);
      quantum = q;
    endfunction

    function int unsigned waiting();
      return reports_due.size();
    endfunction

    function void push_tail(logic [ID_W-1:0] pid, logic [TIME_W-1:0] left);
      ring_pid[tail] = pid;
      ring_left[tail] = left;
      tail = (tail + 1) % QUEUE_DEPTH_DEF;
      depth++;
    endfunction

    // advance the schedule by one accepted item and queue the report it owes
    function void note_item(op_t op, logic [ID_W-1:0] pid, logic [TIME_W-1:0] burst);
      slice_report_t      r;
      logic [TIME_W-1:0]  left;
      logic [CLOCK_W-1:0] prev;
      r = '0;
      items++;
      if (op == OP_ADD) begin
        if (depth >= QUEUE_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          push_tail(pid, burst);
          r.status = ST_ADDED;
        end
      end else if (depth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_SLICE;
        r.pid = ring_pid[head];
        left = ring_left[head];
        head = (head + 1) % QUEUE_DEPTH_DEF;
        depth--;
        r.length = (left > quantum) ? quantum : left;
        r.start_at = clock_now;
        left = left - r.length;
        prev = clock_now;
        clock_now = clock_now + CLOCK_W'(r.length);
        if (clock_now < prev) wrapped = 1;
        r.left = left;
        if (left != 0) push_tail(r.pid, left);
        else r.done = 1'b1;
      end
      r.count = COUNT_W'(depth);
      reports_due.push_back(r);
    endfunction

    function void complain(string what, slice_report_t e, slice_report_t g);
      errors++;
      if (errors <= 10) begin
        $display("%0t ERROR %s", $realtime, what);
        $display("  exp st=%0d id=%02h start=%08h len=%04h rem=%04h fin=%0b cnt=%0d",
                 e.status, e.pid, e.start_at, e.length, e.left, e.done, e.count);
        $display("  got st=%0d id=%02h start=%08h len=%04h rem=%04h fin=%0b cnt=%0d",
                 g.status, g.pid, g.start_at, g.length, g.left, g.done, g.count);
      end
    endfunction

    function void check_result(slice_report_t got);
      slice_report_t exp;
      reports++;
      if (reports_due.size() == 0) begin
        complain("result with no item outstanding", '0, got);
        return;
      end
      exp = reports_due.pop_front();
      status_seen[exp.status]++;
      if (exp.done) finishes++;
      if (got !== exp) complain("report mismatch", exp, got);
    endfunction

    function void check_readback(logic [31:0] rd);
      errors++;
      if (rd[TIME_W-1:0] === quantum) begin
        errors--;
      end else if (errors <= 10) begin
        $display("%0t ERROR quantum readback exp=%04h got=%08h", $realtime, quantum, rd);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Signals and block under test
  // -------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_action;
  logic [ID_W-1:0]     in_process_id;
  logic [TIME_W-1:0]   in_burst_time;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_slice_process_id;
  logic [CLOCK_W-1:0]  out_slice_start;
  logic [TIME_W-1:0]   out_slice_length;
  logic [TIME_W-1:0]   out_remaining_after;
  logic                out_finished;
  logic [COUNT_W-1:0]  out_queue_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  slice_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     cfg_writes = 0;

  round_robin_time_slice_scheduler DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_process_id        (in_process_id),
    .in_burst_time        (in_burst_time),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slice_process_id (out_slice_process_id),
    .out_slice_start      (out_slice_start),
    .out_slice_length     (out_slice_length),
    .out_remaining_after  (out_remaining_after),
    .out_finished         (out_finished),
    .out_queue_count      (out_queue_count),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels at the edge: values seen here are the ones the
  // block itself acted on, so no ordering within the time step matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_item(op_t'(in_action), in_process_id, in_burst_time);
      if (out_valid) begin
        sb.check_result('{status:   status_t'(out_status),
                          pid:      out_slice_process_id,
                          start_at: out_slice_start,
                          length:   out_slice_length,
                          left:     out_remaining_after,
                          done:     out_finished,
                          count:    out_queue_count});
      end
    end
  end

  // Watchdog: stop a hung run well past the slowest legal finish
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, sb.waiting());
      $display("tb_round_robin_time_slice_scheduler failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Start stays high
  // on return so the next item can follow without a gap.
  task automatic send_item(op_t op, logic [ID_W-1:0] pid, logic [TIME_W-1:0] burst);
    start         <= 1'b1;
    in_action     <= op;
    in_process_id <= pid;
    in_burst_time <= burst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for the requested idle time; scramble the idle payload while at it
  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      start         <= 1'b0;
      in_action     <= 1'($urandom);
      in_process_id <= ID_W'($urandom);
      in_burst_time <= TIME_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender off until every owed report has come back. Pass an edge
  // first so an item taken at the current edge is already on the scoreboard.
  task automatic drain_reports();
    start <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  // Mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bursts sized against the quantum so that slices both finish and requeue
  function automatic logic [TIME_W-1:0] pick_burst(logic [TIME_W-1:0] q);
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    top = (q == 0) ? 10 : 3 * q;
    if (top > 65535) top = 65535;
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 24) return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, top));
  endfunction

  // Write a register with the block idle; junk in the unused upper data bits
  task automatic cfg_write(logic [2:0] addr, logic [TIME_W-1:0] value);
    drain_reports();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
    if (addr == QUANTUM_ADDR) sb.set_quantum(value);
    @(posedge clk);
  endtask

  // Read the quantum back and compare it with the scoreboard's copy
  task automatic cfg_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= QUANTUM_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.check_readback(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: the add/slice mix swings between filling and draining so
  // the ring reaches both full and empty; one pause lets everything drain,
  // and one stretch of fifteen items runs with no gaps at all.
  task automatic run_phase(int unsigned n_items);
    int unsigned k;
    int unsigned slice_pct;
    int unsigned pause_at;
    int unsigned quiet_from;
    pause_at   = $urandom_range(5, n_items - 5);
    quiet_from = $urandom_range(0, n_items - 15);
    slice_pct  = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: slice_pct = 25;
          1: slice_pct = 75;
          default: slice_pct = 50;
        endcase
      end
      if ($urandom_range(1, 100) <= slice_pct)
        send_item(OP_SLICE, ID_W'($urandom), TIME_W'($urandom));
      else
        send_item(OP_ADD, ID_W'($urandom), pick_burst(sb.quantum));
      if (k == pause_at)
        drain_reports();
      else if (k < quiet_from || k >= quiet_from + 15)
        idle_for(pick_gap());
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned i;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= OP_ADD;
    in_process_id <= '0;
    in_burst_time <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quantum must come out of reset at its default
    cfg_readback();

    // Directed: slice on an empty ring, zero burst, id and burst extremes,
    // a slice that finishes exactly on the quantum, one that leaves a single
    // unit, filling to the brim, a dropped add and a requeue at full.
    send_item(OP_SLICE, 8'hFF, 16'hFFFF);
    send_item(OP_ADD,   8'h00, 16'h0000);
    send_item(OP_SLICE, 8'h00, 16'h0000);
    idle_for(2);
    send_item(OP_ADD,   8'hFF, 16'hFFFF);
    send_item(OP_ADD,   8'hAA, 16'd60);
    send_item(OP_ADD,   8'h55, 16'd61);
    send_item(OP_SLICE, 8'h5A, 16'h5A5A);
    idle_for(1);
    send_item(OP_SLICE, 8'hA5, 16'hA5A5);
    send_item(OP_SLICE, 8'h00, 16'h0000);
    for (i = 0; i < 14; i++) begin
      send_item(OP_ADD, ID_W'(i * 17 + 3), pick_burst(sb.quantum));
      idle_for(pick_gap());
    end
    send_item(OP_ADD,   8'h7E, 16'h1234);
    send_item(OP_SLICE, 8'h00, 16'h0000);
    idle_for(3);

    run_phase(60);

    // quantum of one: at most one unit per slice
    cfg_write(QUANTUM_ADDR, 16'd1);
    cfg_readback();
    run_phase(60);

    // largest quantum: every slice finishes its process
    cfg_write(QUANTUM_ADDR, 16'hFFFF);
    cfg_readback();
    run_phase(60);

    // write to an address with no register behind it; the quantum must hold
    cfg_write(SPARE_ADDR, TIME_W'($urandom_range(1, 65534)));
    cfg_readback();
    run_phase(40);

    // zero quantum: slices run for nothing; processes with time left requeue unchanged
    cfg_write(QUANTUM_ADDR, 16'd0);
    cfg_readback();
    run_phase(50);

    cfg_write(QUANTUM_ADDR, TIME_W'($urandom_range(2, 300)));
    cfg_readback();
    run_phase(60);

    // Pair full-burst adds with full-quantum slices, back to back, so the
    // elapsed time takes its largest steps.
    cfg_write(QUANTUM_ADDR, 16'hFFFF);
    for (i = 0; i < 4; i++) begin
      send_item(OP_ADD, ID_W'($urandom), 16'hFFFF);
      send_item(OP_SLICE, ID_W'($urandom), TIME_W'($urandom));
    end

    cfg_write(QUANTUM_ADDR, TIME_W'($urandom_range(1, 65535)));
    cfg_readback();
    run_phase(60);

    // let the pipeline empty, then wait on to catch stray strobes
    drain_reports();
    repeat (8) @(posedge clk);

    $display("Covered %0d items and %0d reports: %0d added, %0d dropped full, %0d slices, %0d empty.",
             sb.items, sb.reports, sb.status_seen[ST_ADDED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_SLICE], sb.status_seen[ST_EMPTY]);
    $display("%0d processes finished, %0d register writes, elapsed-time wrap %s, %0d errors.",
             sb.finishes, cfg_writes, sb.wrapped ? "reached" : "missed", sb.errors);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("tb_round_robin_time_slice_scheduler passed");
    end else begin
      $display("tb_round_robin_time_slice_scheduler failed");
    end
    $finish;
  end

endmodule
